>>> hdl/pabt_pkg.sv
// shared constants for the period aligned base time pipeline
// no dependencies
package pabt_pkg;
    localparam int SEC_W    = 34;
    localparam int NSEC_W   = 30;
    localparam int PERIOD_W = 40;
    localparam int TOTAL_W  = 64;
    localparam int QSEC_W   = 11;
    localparam int HALF_W   = 17;
    localparam logic [NSEC_W-1:0]   NS_PER_SEC = NSEC_W'(1000000000);
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000000);
endpackage

>>> hdl/pabt_mul.sv
// two stage total nanosecond count: seconds times one billion plus nanoseconds
// depends on pabt_pkg
module pabt_mul import pabt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SEC_W-1:0]   i_sec,
    input  logic [NSEC_W-1:0]  i_nsec,
    output logic               o_valid,
    output logic [TOTAL_W-1:0] o_total,
    output logic [SEC_W-1:0]   o_sec,
    output logic [NSEC_W-1:0]  o_nsec
);
    localparam int PHI_W = SEC_W - HALF_W + NSEC_W;
    localparam int PLO_W = HALF_W + NSEC_W + 1;

    logic               r_v1, r_v2;
    logic [PHI_W-1:0]   r_phi;
    logic [PLO_W-1:0]   r_plo;
    logic [SEC_W-1:0]   r_sec1, r_sec2;
    logic [NSEC_W-1:0]  r_nsec1, r_nsec2;
    logic [TOTAL_W-1:0] r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phi   <= PHI_W'(i_sec[SEC_W-1:HALF_W]) * PHI_W'(NS_PER_SEC);
            r_plo   <= PLO_W'(PLO_W'(i_sec[HALF_W-1:0]) * PLO_W'(NS_PER_SEC))
                       + PLO_W'(i_nsec);
            r_sec1  <= i_sec;
            r_nsec1 <= i_nsec;
            r_total <= (TOTAL_W'(r_phi) << HALF_W) + TOTAL_W'(r_plo);
            r_sec2  <= r_sec1;
            r_nsec2 <= r_nsec1;
        end
    end

    assign o_valid = r_v2;
    assign o_total = r_total;
    assign o_sec   = r_sec2;
    assign o_nsec  = r_nsec2;
endmodule

>>> hdl/pabt_mod.sv
// pipelined restoring remainder of the total count by the period, one bit per stage
// depends on pabt_pkg
module pabt_mod import pabt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic                i_valid,
    input  logic [TOTAL_W-1:0]  i_total,
    input  logic [SEC_W-1:0]    i_sec,
    input  logic [NSEC_W-1:0]   i_nsec,
    output logic                o_valid,
    output logic [PERIOD_W-1:0] o_rem,
    output logic [SEC_W-1:0]    o_sec,
    output logic [NSEC_W-1:0]   o_nsec
);
    logic [TOTAL_W:0]    r_v;
    logic [PERIOD_W-1:0] r_rem   [TOTAL_W+1];
    logic [TOTAL_W-1:0]  r_total [TOTAL_W+1];
    logic [SEC_W-1:0]    r_sec   [TOTAL_W+1];
    logic [NSEC_W-1:0]   r_nsec  [TOTAL_W+1];

    assign r_v[0]     = i_valid;
    assign r_rem[0]   = '0;
    assign r_total[0] = i_total;
    assign r_sec[0]   = i_sec;
    assign r_nsec[0]  = i_nsec;

    for (genvar k = 0; k < TOTAL_W; k++) begin : g_step
        logic [PERIOD_W:0] n_shift;
        logic [PERIOD_W:0] n_diff;
        assign n_shift = {r_rem[k], r_total[k][TOTAL_W-1-k]};
        assign n_diff  = n_shift - {1'b0, i_period};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]   <= (n_shift >= {1'b0, i_period}) ?
                                n_diff[PERIOD_W-1:0] : n_shift[PERIOD_W-1:0];
                r_total[k+1] <= r_total[k];
                r_sec[k+1]   <= r_sec[k];
                r_nsec[k+1]  <= r_nsec[k];
            end
        end
    end

    assign o_valid = r_v[TOTAL_W];
    assign o_rem   = (i_period == '0) ? '0 : r_rem[TOTAL_W];
    assign o_sec   = r_sec[TOTAL_W];
    assign o_nsec  = r_nsec[TOTAL_W];
endmodule

>>> hdl/pabt_split.sv
// splits the remainder into seconds and nanoseconds, one quotient bit per stage
// depends on pabt_pkg
module pabt_split import pabt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [PERIOD_W-1:0] i_rem,
    input  logic [SEC_W-1:0]    i_sec,
    input  logic [NSEC_W-1:0]   i_nsec,
    output logic                o_valid,
    output logic [QSEC_W-1:0]   o_rsec,
    output logic [NSEC_W-1:0]   o_rnsec,
    output logic [SEC_W-1:0]    o_sec,
    output logic [NSEC_W-1:0]   o_nsec
);
    logic [QSEC_W:0]     r_v;
    logic [PERIOD_W-1:0] r_r    [QSEC_W+1];
    logic [QSEC_W-1:0]   r_q    [QSEC_W+1];
    logic [SEC_W-1:0]    r_sec  [QSEC_W+1];
    logic [NSEC_W-1:0]   r_nsec [QSEC_W+1];

    assign r_v[0]    = i_valid;
    assign r_r[0]    = i_rem;
    assign r_q[0]    = '0;
    assign r_sec[0]  = i_sec;
    assign r_nsec[0] = i_nsec;

    for (genvar k = 0; k < QSEC_W; k++) begin : g_bit
        localparam logic [PERIOD_W:0] DIV =
            (PERIOD_W+1)'(NS_PER_SEC) << (QSEC_W-1-k);
        logic [PERIOD_W:0] n_diff;
        logic              n_ge;
        assign n_diff = {1'b0, r_r[k]} - DIV;
        assign n_ge   = {1'b0, r_r[k]} >= DIV;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k+1]    <= n_ge ? n_diff[PERIOD_W-1:0] : r_r[k];
                r_q[k+1]    <= r_q[k] | (n_ge ? (QSEC_W'(1) << (QSEC_W-1-k)) : '0);
                r_sec[k+1]  <= r_sec[k];
                r_nsec[k+1] <= r_nsec[k];
            end
        end
    end

    assign o_valid = r_v[QSEC_W];
    assign o_rsec  = r_q[QSEC_W];
    assign o_rnsec = r_r[QSEC_W][NSEC_W-1:0];
    assign o_sec   = r_sec[QSEC_W];
    assign o_nsec  = r_nsec[QSEC_W];
endmodule

>>> hdl/period_aligned_base_time.sv
// period aligned base time: start of the period that holds a timestamp
// pipeline: multiply, remainder and split stages, then a borrow and output register
// throughput one transaction per cycle; the whole pipeline stalls while a result waits
// synchronous active low reset clears all valid bits and loads period_ns with 1000000
// depends on pabt_pkg, pabt_mul, pabt_mod, pabt_split
module period_aligned_base_time import pabt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SEC_W-1:0]    i_time_sec,
    input  logic [NSEC_W-1:0]   i_time_nanosec,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SEC_W-1:0]    o_base_sec,
    output logic [NSEC_W-1:0]   o_base_nanosec,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_data
);
    logic [PERIOD_W-1:0] r_period_ns;
    logic                en;
    logic                m_valid, d_valid, s_valid;
    logic [TOTAL_W-1:0]  m_total;
    logic [SEC_W-1:0]    m_sec, d_sec, s_sec;
    logic [NSEC_W-1:0]   m_nsec, d_nsec, s_nsec, s_rnsec;
    logic [PERIOD_W-1:0] d_rem;
    logic [QSEC_W-1:0]   s_rsec;
    logic                r_out_valid;
    logic [SEC_W-1:0]    r_base_sec;
    logic [NSEC_W-1:0]   r_base_nsec;
    logic                n_borrow;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ns <= PERIOD_RST;
        end else if (i_cfg_we) begin
            r_period_ns <= i_cfg_data;
        end
    end

    pabt_mul u_mul (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_in_valid && en),
        .i_sec(i_time_sec), .i_nsec(i_time_nanosec),
        .o_valid(m_valid), .o_total(m_total), .o_sec(m_sec), .o_nsec(m_nsec)
    );

    pabt_mod u_mod (
        .i_clk, .i_rst_n, .i_en(en), .i_period(r_period_ns),
        .i_valid(m_valid), .i_total(m_total), .i_sec(m_sec), .i_nsec(m_nsec),
        .o_valid(d_valid), .o_rem(d_rem), .o_sec(d_sec), .o_nsec(d_nsec)
    );

    pabt_split u_split (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_valid),
        .i_rem(d_rem), .i_sec(d_sec), .i_nsec(d_nsec),
        .o_valid(s_valid), .o_rsec(s_rsec), .o_rnsec(s_rnsec),
        .o_sec(s_sec), .o_nsec(s_nsec)
    );

    assign n_borrow = s_nsec < s_rnsec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_base_sec  <= s_sec - SEC_W'(s_rsec) - SEC_W'(n_borrow);
            r_base_nsec <= n_borrow ? (s_nsec + NS_PER_SEC - s_rnsec)
                                    : (s_nsec - s_rnsec);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_base_sec     = r_base_sec;
    assign o_base_nanosec = r_base_nsec;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while pipeline stalled");
endmodule

>>> tb/period_aligned_base_time_tb.sv
`timescale 1ns / 1ps
// testbench for period_aligned_base_time: directed table, then random timestamps
// over several period settings, results checked against table or local predictor
// depends on pabt_pkg and the period_aligned_base_time rtl
module period_aligned_base_time_tb;
    import pabt_pkg::*;

    localparam longint unsigned NS_SEC  = 64'd1000000000;
    localparam int              WD_MAX  = 4000;
    localparam int              N_PHASE = 6;
    localparam int              N_RAND  = 256;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
    } t_stamp;

    typedef struct {
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
        bit                known;
        t_stamp            base;
    } t_vec;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [SEC_W-1:0]    i_time_sec;
    logic [NSEC_W-1:0]   i_time_nanosec;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [SEC_W-1:0]    o_base_sec;
    logic [NSEC_W-1:0]   o_base_nanosec;
    logic                i_cfg_we;
    logic [PERIOD_W-1:0] i_cfg_data;

    logic [PERIOD_W-1:0] cur_period;
    t_stamp              base_q[$];
    int                  n_err;
    int                  in_idle;
    int                  out_idle;
    int                  idle_cnt = 0;

    period_aligned_base_time DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_time_sec     (i_time_sec),
        .i_time_nanosec (i_time_nanosec),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_base_sec     (o_base_sec),
        .o_base_nanosec (o_base_nanosec),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_stamp period_base(logic [SEC_W-1:0] sec, logic [NSEC_W-1:0] nsec,
                                           logic [PERIOD_W-1:0] per);
        longint unsigned total;
        longint unsigned rem;
        longint unsigned rsec;
        longint unsigned rnsec;
        longint unsigned bsec;
        longint unsigned bnsec;
        t_stamp          r;
        total = longint'(sec) * NS_SEC + longint'(nsec);
        rem   = (per != 0) ? total % longint'(per) : 64'd0;
        rsec  = rem / NS_SEC;
        rnsec = rem % NS_SEC;
        bsec  = longint'(sec) - rsec;
        if (longint'(nsec) < rnsec) begin
            bsec  = bsec - 1;
            bnsec = longint'(nsec) + NS_SEC - rnsec;
        end else begin
            bnsec = longint'(nsec) - rnsec;
        end
        r.sec  = bsec[SEC_W-1:0];
        r.nsec = bnsec[NSEC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
        n_err++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    endtask

    // one input transaction, random gap first
    task automatic send_stamp(logic [SEC_W-1:0] sec, logic [NSEC_W-1:0] nsec,
                              bit known, t_stamp base);
        while ($urandom_range(99) < in_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_time_sec     = sec;
        i_time_nanosec = nsec;
        do @(posedge i_clk); while (!o_in_ready);
        base_q.push_back(known ? base : period_base(sec, nsec, cur_period));
        @(negedge i_clk);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] per);
        i_in_valid = 1'b0;
        wait (base_q.size() == 0);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = per;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        cur_period = per;
    endtask

    function automatic logic [SEC_W-1:0] rand_sec();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return SEC_W'($urandom_range(20));
            default: return SEC_W'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic logic [NSEC_W-1:0] rand_nsec();
        case ($urandom_range(9))
            0:       return '0;
            1:       return NSEC_W'(999999999);
            2:       return '1;
            3:       return NSEC_W'($urandom());
            default: return NSEC_W'($urandom_range(999999999));
        endcase
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle);
    end

    // result check
    always @(posedge i_clk) begin
        t_stamp e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (base_q.size() == 0) begin
                report_mismatch("unexpected transaction base_sec", longint'(o_base_sec), 0);
            end else begin
                e = base_q.pop_front();
                if (o_base_sec !== e.sec)
                    report_mismatch("base_sec", longint'(o_base_sec), longint'(e.sec));
                if (o_base_nanosec !== e.nsec)
                    report_mismatch("base_nanosec", longint'(o_base_nanosec),
                                    longint'(e.nsec));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WD_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_vec                dir[$];
        logic [PERIOD_W-1:0] periods[N_PHASE];
        int                  total;
        int                  k;
        n_err          = 0;
        in_idle        = 19;
        out_idle       = 62;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_time_sec     = '0;
        i_time_nanosec = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        cur_period     = PERIOD_RST;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset period is 1 ms
        dir.push_back('{'0, '0, 1, '{'0, '0}});
        dir.push_back('{'0, 30'd1, 1, '{'0, '0}});
        dir.push_back('{34'd5, 30'd1000000, 1, '{34'd5, 30'd1000000}});
        dir.push_back('{'1, 30'd999999999, 1, '{'1, 30'd999000000}});
        dir.push_back('{34'd7, '1, 1, '{34'd7, 30'd1073000000}});
        dir.push_back('{'1, '1, 0, '{'0, '0}});
        dir.push_back('{34'h2AAAAAAAA, 30'h15555555, 0, '{'0, '0}});
        dir.push_back('{34'h155555555, 30'd123456789, 0, '{'0, '0}});
        foreach (dir[i]) send_stamp(dir[i].sec, dir[i].nsec, dir[i].known, dir[i].base);

        periods[0] = 40'd1;
        periods[1] = '1;
        periods[2] = '0;
        periods[3] = 40'd1000000000;
        periods[4] = 40'd3;
        periods[5] = PERIOD_W'({$urandom(), $urandom()});
        total = N_PHASE * N_RAND;
        k = 0;
        for (int p = 0; p < N_PHASE; p++) begin
            write_period(periods[p]);
            // borrow check right after each period change
            send_stamp('1, '0, 0, '{'0, '0});
            for (int j = 0; j < N_RAND; j++) begin
                if (k < total / 3) begin
                    in_idle = 19; out_idle = 62;
                end else if (k < 2 * total / 3) begin
                    in_idle = 62; out_idle = 19;
                end else begin
                    in_idle = 0; out_idle = 0;
                end
                k++;
                send_stamp(rand_sec(), rand_nsec(), 0, '{'0, '0});
            end
        end
        i_in_valid = 1'b0;
        wait (base_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> sim.f
hdl/pabt_pkg.sv
hdl/pabt_mul.sv
hdl/pabt_mod.sv
hdl/pabt_split.sv
hdl/period_aligned_base_time.sv
tb/period_aligned_base_time_tb.sv
